// ----- design/q2e_pkg.sv -----
// Shared types, constants and CORDIC helpers for the quaternion to Euler angle block.
// Used by q2e_front, q2e_back and quaternion_to_euler_angles.
`timescale 1ns / 1ps
package q2e_pkg;

  // Field widths
  localparam int QW          = 16;   // quaternion component, Q1.15
  localparam int THRW        = 15;   // pole threshold register
  localparam int CFGW        = 16;   // configuration data bus
  localparam int ANGW        = 16;   // binary angle
  localparam int POLEW       = 2;    // pole case code
  localparam int OPW         = 34;   // atan2 operand (exact integer)
  localparam int SW          = 32;   // saturated asin argument
  localparam int MAGW        = 31;   // magnitude of asin argument
  localparam int SQW         = 61;   // sqrt radicand
  localparam int RESW        = 62;   // sqrt working result
  localparam int SQRT_TOP    = 60;   // highest radicand bit pair
  localparam int SQRT_STEPS  = 31;   // one result bit per step
  localparam int CW          = 52;   // CORDIC datapath
  localparam int ACCW        = 32;   // CORDIC angle accumulator
  localparam int MAX_STAGES  = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [THRW-1:0]       THR_RESET   = 15'd16381;
  localparam logic signed [OPW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [ACCW-1:0]       QUARTER     = 32'h4000_0000;
  localparam logic [ACCW-1:0]       ROUND_HALF  = 32'h0000_8000;
  localparam logic signed [ANGW-1:0] PITCH_MAX  = 16'sd16384;
  localparam logic signed [ANGW-1:0] PITCH_MIN  = -16'sd16384;

  typedef enum logic [POLEW-1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  // One classified request handed from front to back
  typedef struct packed {
    logic signed [OPW-1:0] hd_y;   // heading numerator (or pole y term)
    logic signed [OPW-1:0] hd_x;   // heading denominator (or pole w term)
    logic signed [OPW-1:0] rl_y;
    logic signed [OPW-1:0] rl_x;
    logic signed [SW-1:0]  pt_s;   // saturated 2*test
    logic [MAGW-1:0]       pt_mag; // |pt_s|
    pole_t                 pole;
  } work_t;

  // One CORDIC lane
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ACCW-1:0]      acc;
    logic                 zero;
  } lane_t;

  localparam logic [ACCW-1:0] ATAN_TABLE [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Scale operands by 2^16 and fold the left half plane by a quarter turn
  function automatic lane_t prerotate(input logic signed [OPW-1:0] yv,
                                      input logic signed [OPW-1:0] xv);
    lane_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = {{(CW-OPW-16){xv[OPW-1]}}, xv, 16'h0000};
    ys = {{(CW-OPW-16){yv[OPW-1]}}, yv, 16'h0000};
    r.zero = (xv == '0) && (yv == '0);
    r.acc  = '0;
    r.x    = xs;
    r.y    = ys;
    if (xs < 0) begin
      if (ys >= 0) begin
        r.x   = ys;
        r.y   = -xs;
        r.acc = QUARTER;
      end else begin
        r.x   = -ys;
        r.y   = xs;
        r.acc = '0 - QUARTER;
      end
    end
    return r;
  endfunction

  // One vectoring micro-rotation
  function automatic lane_t cordic_step(input lane_t l, input logic [4:0] idx);
    lane_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = l.x >>> idx;
    ys = l.y >>> idx;
    r  = l;
    if (l.y > 0) begin
      r.x   = l.x + ys;
      r.y   = l.y - xs;
      r.acc = l.acc + ATAN_TABLE[idx];
    end else begin
      r.x   = l.x - ys;
      r.y   = l.y + xs;
      r.acc = l.acc - ATAN_TABLE[idx];
    end
    return r;
  endfunction

endpackage

// ----- design/q2e_fifo.sv -----
// Small request queue between front and back; register array, combinational read.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module q2e_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0]   count_r, count_nxt;

  // advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;
endmodule

// ----- design/q2e_front.sv -----
// Front end: accepts quaternions, forms the products, classifies pole cases and
// builds the atan2 / asin operands. Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [4*q2e_pkg::QW-1:0]              in_tdata,
  input  logic                                  cfg_tvalid,
  input  logic [q2e_pkg::CFGW-1:0]              cfg_tdata,
  input  logic [$clog2(q2e_pkg::FIFO_DEPTH+1)-1:0] fifo_count,
  output logic                                  push,
  output q2e_pkg::work_t                        push_data
);
  localparam int QW  = q2e_pkg::QW;
  localparam int OPW = q2e_pkg::OPW;
  localparam int PW  = 2 * QW;
  localparam int CNW = $clog2(q2e_pkg::FIFO_DEPTH+1);

  logic [q2e_pkg::THRW-1:0] thr_r;
  logic                     a_vld_r, b_vld_r;
  logic signed [QW-1:0]     a_w_r, a_x_r, a_y_r, a_z_r;
  logic signed [QW-1:0]     b_w_r, b_y_r;
  logic signed [PW-1:0]     p_yz_r, p_xw_r, p_zw_r, p_yx_r, p_zz_r, p_xx_r;
  logic signed [PW-1:0]     p_yw_r, p_zx_r, p_yy_r;
  logic [CNW-1:0]           occ;
  logic                     accept;

  // hold a place in the queue for every request in flight
  assign occ       = fifo_count + CNW'(a_vld_r) + CNW'(b_vld_r);
  assign in_tready = (occ < CNW'(q2e_pkg::FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= q2e_pkg::THR_RESET;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (cfg_tvalid) begin
        thr_r <= cfg_tdata[q2e_pkg::THRW-1:0];
      end
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
    end
  end

  // capture components, then form all products
  always_ff @(posedge clk) begin
    if (accept) begin
      a_w_r <= in_tdata[QW-1:0];
      a_x_r <= in_tdata[2*QW-1:QW];
      a_y_r <= in_tdata[3*QW-1:2*QW];
      a_z_r <= in_tdata[4*QW-1:3*QW];
    end
    p_yz_r <= a_y_r * a_z_r;
    p_xw_r <= a_x_r * a_w_r;
    p_zw_r <= a_z_r * a_w_r;
    p_yx_r <= a_y_r * a_x_r;
    p_zz_r <= a_z_r * a_z_r;
    p_xx_r <= a_x_r * a_x_r;
    p_yw_r <= a_y_r * a_w_r;
    p_zx_r <= a_z_r * a_x_r;
    p_yy_r <= a_y_r * a_y_r;
    b_w_r  <= a_w_r;
    b_y_r  <= a_y_r;
  end

  // classify and build operands
  logic signed [OPW-1:0] test, thr, s2, sc;
  always_comb begin
    test = OPW'(p_yz_r) + OPW'(p_xw_r);
    thr  = $signed({4'b0000, thr_r, 15'h0000});
    s2   = test <<< 1;
    sc   = s2;
    if (s2 > q2e_pkg::ONE_Q30) begin
      sc = q2e_pkg::ONE_Q30;
    end else if (s2 < -q2e_pkg::ONE_Q30) begin
      sc = -q2e_pkg::ONE_Q30;
    end
    push_data.rl_y   = (OPW'(p_yw_r) - OPW'(p_zx_r)) <<< 1;
    push_data.rl_x   = q2e_pkg::ONE_Q30 - ((OPW'(p_yy_r) + OPW'(p_xx_r)) <<< 1);
    push_data.pt_s   = q2e_pkg::SW'(sc);
    push_data.pt_mag = (sc < 0) ? q2e_pkg::MAGW'(-sc) : q2e_pkg::MAGW'(sc);
    if (test > thr) begin
      push_data.pole = q2e_pkg::POLE_NORTH;
    end else if (test < -thr) begin
      push_data.pole = q2e_pkg::POLE_SOUTH;
    end else begin
      push_data.pole = q2e_pkg::POLE_NONE;
    end
    if (push_data.pole != q2e_pkg::POLE_NONE) begin
      push_data.hd_y = OPW'(b_y_r) <<< 15;
      push_data.hd_x = OPW'(b_w_r) <<< 15;
    end else begin
      push_data.hd_y = (OPW'(p_zw_r) - OPW'(p_yx_r)) <<< 1;
      push_data.hd_x = q2e_pkg::ONE_Q30 - ((OPW'(p_zz_r) + OPW'(p_xx_r)) <<< 1);
    end
  end

  assign push = b_vld_r;
endmodule

// ----- design/q2e_back.sv -----
// Back end: pitch cosine by pipelined square root, three CORDIC lanes, rounding
// and pole overrides into the output register. Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_back #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  q2e_pkg::work_t             pop_data,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [3*q2e_pkg::ANGW-1:0] out_tdata,
  output logic [q2e_pkg::POLEW-1:0]  out_tuser
);
  localparam int NS    = (CORDIC_STAGES > q2e_pkg::MAX_STAGES) ?
                         q2e_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int SQW   = q2e_pkg::SQW;
  localparam int RESW  = q2e_pkg::RESW;
  localparam int MAGW  = q2e_pkg::MAGW;
  localparam int OPW   = q2e_pkg::OPW;
  localparam int ANGW  = q2e_pkg::ANGW;
  localparam int ACCW  = q2e_pkg::ACCW;
  localparam int STEPS = q2e_pkg::SQRT_STEPS;
  localparam logic [SQW-1:0] ONE_Q60 = SQW'(1) << q2e_pkg::SQRT_TOP;

  logic en;
  logic out_vld_r;

  // advance the whole pipeline unless the result register is held
  assign en  = !out_vld_r || out_tready;
  assign pop = en && !empty;

  // square of the asin argument
  logic                 s0_vld_r;
  q2e_pkg::work_t       s0_item_r;
  logic [SQW-1:0]       s0_sq_r;
  logic [2*MAGW-1:0]    mag_sq;
  assign mag_sq = pop_data.pt_mag * pop_data.pt_mag;

  // square root steps
  logic                 sq_vld_r  [STEPS+1];
  q2e_pkg::work_t       sq_item_r [STEPS+1];
  logic [SQW-1:0]       sq_rem_r  [STEPS+1];
  logic [RESW-1:0]      sq_res_r  [STEPS+1];

  // CORDIC lanes: 0 heading, 1 pitch, 2 roll
  logic                 cr_vld_r  [NS+1];
  q2e_pkg::pole_t       cr_pole_r [NS+1];
  q2e_pkg::lane_t       cr_lane_r [NS+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      for (int i = 0; i <= STEPS; i++) begin
        sq_vld_r[i] <= 1'b0;
      end
      for (int i = 0; i <= NS; i++) begin
        cr_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      s0_vld_r    <= pop;
      sq_vld_r[0] <= s0_vld_r;
      for (int i = 0; i < STEPS; i++) begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
      cr_vld_r[0] <= sq_vld_r[STEPS];
      for (int i = 0; i < NS; i++) begin
        cr_vld_r[i+1] <= cr_vld_r[i];
      end
    end
  end

  // take the request and square its magnitude, then form the radicand
  always_ff @(posedge clk) begin
    if (en) begin
      s0_item_r    <= pop_data;
      s0_sq_r      <= mag_sq[SQW-1:0];
      sq_item_r[0] <= s0_item_r;
      sq_rem_r[0]  <= ONE_Q60 - s0_sq_r;
      sq_res_r[0]  <= '0;
    end
  end

  // one result bit per step
  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [RESW-1:0] BIT = RESW'(1) << (q2e_pkg::SQRT_TOP - 2*k);
    logic [RESW-1:0] trial;
    logic            ge;
    assign trial = sq_res_r[k] + BIT;
    assign ge    = ({1'b0, sq_rem_r[k]} >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_item_r[k+1] <= sq_item_r[k];
        if (ge) begin
          sq_rem_r[k+1] <= sq_rem_r[k] - trial[SQW-1:0];
          sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BIT;
        end else begin
          sq_rem_r[k+1] <= sq_rem_r[k];
          sq_res_r[k+1] <= sq_res_r[k] >> 1;
        end
      end
    end
  end

  // scale and fold all three lanes
  q2e_pkg::work_t       sq_last;
  logic signed [OPW-1:0] pt_y, pt_x;
  assign sq_last = sq_item_r[STEPS];
  assign pt_y    = OPW'(sq_last.pt_s);
  assign pt_x    = $signed({{(OPW-MAGW){1'b0}}, sq_res_r[STEPS][MAGW-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      cr_pole_r[0]    <= sq_last.pole;
      cr_lane_r[0][0] <= q2e_pkg::prerotate(sq_last.hd_y, sq_last.hd_x);
      cr_lane_r[0][1] <= q2e_pkg::prerotate(pt_y, pt_x);
      cr_lane_r[0][2] <= q2e_pkg::prerotate(sq_last.rl_y, sq_last.rl_x);
    end
  end

  // micro-rotation stages
  for (genvar s = 0; s < NS; s++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        cr_pole_r[s+1] <= cr_pole_r[s];
        for (int l = 0; l < 3; l++) begin
          cr_lane_r[s+1][l] <= q2e_pkg::cordic_step(cr_lane_r[s][l], 5'(s));
        end
      end
    end
  end

  // round, clamp and apply pole overrides
  logic [ACCW-1:0]        acc_h, acc_p, acc_r, sum_h, sum_p, sum_r;
  logic signed [ANGW-1:0] head_nxt, pitch_nxt, roll_nxt, p16;
  q2e_pkg::pole_t         pole_f;
  always_comb begin
    pole_f = cr_pole_r[NS];
    acc_h  = cr_lane_r[NS][0].zero ? '0 : cr_lane_r[NS][0].acc;
    acc_p  = cr_lane_r[NS][1].zero ? '0 : cr_lane_r[NS][1].acc;
    acc_r  = cr_lane_r[NS][2].zero ? '0 : cr_lane_r[NS][2].acc;
    sum_p  = acc_p + q2e_pkg::ROUND_HALF;
    sum_r  = acc_r + q2e_pkg::ROUND_HALF;
    p16    = sum_p[ACCW-1:ACCW-ANGW];
    if (pole_f != q2e_pkg::POLE_NONE) begin
      sum_h     = {acc_h[ACCW-2:0], 1'b0} + q2e_pkg::ROUND_HALF;
      pitch_nxt = (pole_f == q2e_pkg::POLE_NORTH) ? q2e_pkg::PITCH_MAX : q2e_pkg::PITCH_MIN;
      roll_nxt  = '0;
    end else begin
      sum_h     = acc_h + q2e_pkg::ROUND_HALF;
      roll_nxt  = sum_r[ACCW-1:ACCW-ANGW];
      if (p16 > q2e_pkg::PITCH_MAX) begin
        pitch_nxt = q2e_pkg::PITCH_MAX;
      end else if (p16 < q2e_pkg::PITCH_MIN) begin
        pitch_nxt = q2e_pkg::PITCH_MIN;
      end else begin
        pitch_nxt = p16;
      end
    end
    head_nxt = sum_h[ACCW-1:ACCW-ANGW];
  end

  logic [3*ANGW-1:0]          out_data_r;
  logic [q2e_pkg::POLEW-1:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cr_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {roll_nxt, pitch_nxt, head_nxt};
      out_user_r <= pole_f;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule

// ----- design/quaternion_to_euler_angles.sv -----
// Top level of the quaternion to heading / pitch / roll converter.
// Depends on q2e_pkg, q2e_front, q2e_fifo and q2e_back.
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | tdata: quat_w, quat_x, quat_y, quat_z (16 b each)
//  out_    | master    | tdata: heading, pitch, roll (16 b each); tuser: pole_case
//  cfg_    | slave     | tdata[14:0]: pole_threshold, always ready
//
// One request per cycle is accepted and one result per cycle delivered while the
// queue has room and the output is not held. Requests pass the front stages, the
// queue, the square root (one bit per step), the fold, the CORDIC stages, the output.
// Reset (rst_n low, synchronous) empties all stages and sets pole_threshold to 16381.
// A held output stalls the back pipeline; the 4-entry queue absorbs the front.
`timescale 1ns / 1ps
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [4*q2e_pkg::QW-1:0]      in_tdata,    // quat_w, quat_x, quat_y, quat_z
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [3*q2e_pkg::ANGW-1:0]    out_tdata,   // heading_angle, pitch_angle, roll_angle
  output logic [q2e_pkg::POLEW-1:0]     out_tuser,   // pole_case
  input  logic                          cfg_tvalid,
  output logic                          cfg_tready,
  input  logic [q2e_pkg::CFGW-1:0]      cfg_tdata    // pole_threshold, top bit zero
);
  localparam int CNW = $clog2(q2e_pkg::FIFO_DEPTH+1);

  logic                 push, pop, empty;
  q2e_pkg::work_t       push_data, pop_data;
  logic [CNW-1:0]       fifo_count;

  assign cfg_tready = 1'b1;

  q2e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tdata  (cfg_tdata),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  q2e_fifo #(
    .WIDTH ($bits(q2e_pkg::work_t)),
    .DEPTH (q2e_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .count     (fifo_count)
  );

  q2e_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_data   (pop_data),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule

// ----- tb/sv/q2e_checker.sv -----
// Scoreboard for the quaternion to heading / pitch / roll converter.
// Watches the in_, cfg_ and out_ channels, predicts each result and counts mismatches.
// Depends on q2e_pkg for the stage count, the reset threshold and the pole case codes.
`timescale 1ns / 1ps
module q2e_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_tvalid,
  input  logic        cfg_tready,
  input  logic [15:0] cfg_tdata,
  output int          err_count,
  output int          pending
);
  localparam int STAGES = (q2e_pkg::CORDIC_STAGES_DEF > q2e_pkg::MAX_STAGES) ?
                          q2e_pkg::MAX_STAGES : q2e_pkg::CORDIC_STAGES_DEF;

  localparam logic [31:0] ARCTAN [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [15:0]     heading;
    logic [15:0]     pitch;
    logic [15:0]     roll;
    q2e_pkg::pole_t  pole;
  } euler_t;

  euler_t      euler_q[$];
  logic [14:0] threshold;

  assign pending = euler_q.size();

  // Vectoring rotation; angle with a full turn of 2^32
  function automatic logic [31:0] vector_angle(longint vy, longint vx);
    logic [31:0] acc;
    longint t, xs, ys;
    acc = '0;
    if (vx == 0 && vy == 0) return '0;
    vx = vx * 65536;
    vy = vy * 65536;
    if (vx < 0) begin
      if (vy >= 0) begin
        t = vx; vx = vy; vy = -t; acc = 32'h4000_0000;
      end else begin
        t = vx; vx = -vy; vy = t; acc = 32'hC000_0000;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx += ys; vy -= xs; acc += ARCTAN[i];
      end else begin
        vx -= ys; vy += xs; acc -= ARCTAN[i];
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] to_bam(logic [31:0] acc);
    logic [31:0] r;
    r = acc + 32'h8000;
    return r[31:16];
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_euler(logic [63:0] q, logic [14:0] thr_reg);
    euler_t e;
    longint w, x, y, z, tst, thr, hn, hd, rn, rd, s, c, p;
    longint unsigned mag;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    tst = y * z + x * w;
    thr = longint'(thr_reg) * 32768;
    if (tst > thr || tst < -thr) begin
      e.heading = to_bam(vector_angle(y * 32768, w * 32768) * 2);
      e.pitch   = (tst > thr) ? 16'sd16384 : -16'sd16384;
      e.roll    = '0;
      e.pole    = (tst > thr) ? q2e_pkg::POLE_NORTH : q2e_pkg::POLE_SOUTH;
      return e;
    end
    hn = 2 * (z * w - y * x);
    hd = (64'sd1 << 30) - 2 * (z * z + x * x);
    rn = 2 * (y * w - z * x);
    rd = (64'sd1 << 30) - 2 * (y * y + x * x);
    s  = 2 * tst;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
    mag = (s < 0) ? -s : s;
    c = floor_sqrt((64'd1 << 60) - mag * mag);
    p = longint'($signed(to_bam(vector_angle(s, c))));
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    e.heading = to_bam(vector_angle(hn, hd));
    e.pitch   = p[15:0];
    e.roll    = to_bam(vector_angle(rn, rd));
    e.pole    = q2e_pkg::POLE_NONE;
    return e;
  endfunction

  // Track the register, queue predictions, compare results in order
  always @(posedge clk) begin
    euler_t want;
    if (!rst_n) begin
      threshold <= q2e_pkg::THR_RESET;
      err_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        euler_q.insert(euler_q.size(), predict_euler(in_tdata, threshold));
      if (cfg_tvalid && cfg_tready) threshold <= cfg_tdata[14:0];
      if (out_tvalid && out_tready) begin
        if (euler_q.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10) $display("unexpected result %h/%0d", out_tdata, out_tuser);
        end else begin
          want = euler_q.pop_front();
          if (want.heading != out_tdata[15:0] || want.pitch != out_tdata[31:16] ||
              want.roll != out_tdata[47:32] || want.pole != out_tuser) begin
            err_count <= err_count + 1;
            if (err_count < 10)
              $display("mismatch: exp h=%0d p=%0d r=%0d pole=%0d got h=%0d p=%0d r=%0d pole=%0d",
                       $signed(want.heading), $signed(want.pitch), $signed(want.roll), want.pole,
                       $signed(out_tdata[15:0]), $signed(out_tdata[31:16]),
                       $signed(out_tdata[47:32]), out_tuser);
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Stimulus and verdict for the quaternion to heading / pitch / roll converter.
// Instantiates quaternion_to_euler_angles and q2e_checker; uses q2e_pkg.
`timescale 1ns / 1ps
module tb_top;

  localparam int DRAIN = 80;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_tvalid, cfg_tready;
  logic [15:0] cfg_tdata;
  int          err_count, pending;
  bit          hold_long;

  quaternion_to_euler_angles u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  q2e_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: own stall pattern, one long hold-off on request
  initial begin
    int mode;
    out_tready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_long = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Send one request, holding valid until accepted
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x, w};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Write the threshold with the block idle
  task automatic set_threshold(logic [14:0] thr);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {1'b0, thr};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
  endtask

  // Random unit-ish quaternion, sometimes near a pole, sometimes raw bits
  task automatic send_random();
    int kind;
    logic [15:0] w, x, y, z;
    kind = $urandom_range(0, 9);
    w = $urandom; x = $urandom; y = $urandom; z = $urandom;
    if (kind < 6) begin
      // scale down: components within +-0.25
      w = {{2{w[15]}}, w[15:2]}; x = {{2{x[15]}}, x[15:2]};
      y = {{2{y[15]}}, y[15:2]}; z = {{2{z[15]}}, z[15:2]};
    end else if (kind < 8) begin
      // near a pole: y*z + x*w close to +-0.5
      x = 16'sd23170 + $signed(16'($urandom_range(0, 800)) - 16'sd400);
      w = $urandom_range(0, 1) ? 16'sd23170 : -16'sd23170;
      w = w + $signed(16'($urandom_range(0, 800)) - 16'sd400);
      y = $signed(16'($urandom_range(0, 2000)) - 16'sd1000);
      z = $signed(16'($urandom_range(0, 2000)) - 16'sd1000);
    end
    send_quat(w, x, y, z);
  endtask

  initial begin
    logic [14:0] thr_list [5];
    int burst;
    thr_list = '{15'd0, 15'd32767, 15'd16384, 15'd8000, 15'd16381};
    hold_long = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero vector, both poles, identity, saturated asin
    send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000);
    send_quat(16'h5A82, 16'hA57E, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h5A82, 16'h5A82);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
    send_quat(16'h4000, 16'hC000, 16'h4000, 16'hC000);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'h5A7F, 16'h5A7F, 16'h0000, 16'h0000);
    idle_gap(1);

    // Long receiver hold-off while requests keep coming
    hold_long = 1'b1;
    repeat (60) send_random();

    // Phases across threshold settings
    foreach (thr_list[k]) begin
      set_threshold(thr_list[k]);
      for (int n = 0; n < 300; n++) begin
        send_random();
        if (burst <= 0) begin
          burst = $urandom_range(0, 40);
          if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
        end
        burst--;
      end
      // pause until everything has come back
      in_tvalid <= 1'b0;
      while (pending != 0) @(posedge clk);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
